>>> rtl/assert_macros.svh
// Assertion macros shared by the max filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent check, switched off while reset is held.
`define MF3_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Concurrent check that also runs through reset.
`define MF3_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MF3_ASSERT(lbl, clk, rst_n, prop, msg)
`define MF3_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/mf3_pkg.sv
// Types and constants of the 3x3 max filter.
`timescale 1ns / 1ps
package mf3_pkg;

    localparam int MAX_SIDE   = 1024;
    localparam int PIXEL_BITS = 16;
    localparam int FIELD_BITS = 16;
    localparam int SIDE_BITS  = 11;
    localparam int POS_BITS   = $clog2(MAX_SIDE);
    localparam int PTR_BITS   = $clog2(MAX_SIDE);
    localparam int CNT_BITS   = 2 * $clog2(MAX_SIDE) + 1;
    localparam int DATA_BITS  = 32;
    localparam int ADDR_BITS  = 3;

    localparam int SIDE_RESET = 64;
    localparam int N_RESET    = SIDE_RESET * SIDE_RESET;

    localparam logic [0:0] REG_SIDE_LENGTH = 1'b0;

    typedef logic [PIXEL_BITS-1:0] t_pix;

    // One column of the window: rows above, centre and below.
    typedef struct packed {
        t_pix top;
        t_pix mid;
        t_pix bot;
    } t_col;

    // Which outer rows of a column lie inside the image.
    typedef struct packed {
        logic up;
        logic dn;
    } t_row_mask;

    typedef struct packed {
        t_row_mask rows;
        logic      lf;
        logic      rt;
        logic      single;
        logic      last;
    } t_s1_flags;

endpackage

>>> rtl/neighbourhood_max_filter_3x3_top.sv
// Top level of the 3x3 neighbourhood max filter.
//
// Pixels of a square image enter in raster order on the input channel
// (i_in_valid / o_in_stall); results leave on the output channel
// (o_out_valid / i_out_stall). Each item carries a pixel or a drain mark.
// The result for a pixel is due once the pixel side+1 places later has
// arrived, so after the last pixel of an image the sender gives side+1
// items (drain or pixel) to push out the remaining results; frame_last
// marks the final one. Drain items before the image is complete are dropped.
// One item is taken per cycle while the input is not stalled; a result
// passes from the item that completes its window through the window cells
// and then the output register. The single-port line store reads and writes
// one entry per accepted pixel and per filler item past the image.
// Side length sits at byte address 0 of the APB port; writing it abandons
// any partial image. Reset sets side 64 and empties the pipeline; line
// store contents stay undefined and are masked by the image borders.
// While the output is stalled and a result waits behind it, the input
// stalls; otherwise the block keeps taking items.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module neighbourhood_max_filter_3x3_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [mf3_pkg::FIELD_BITS-1:0]    i_pixel_value,
    input  logic                              i_drain,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [mf3_pkg::FIELD_BITS-1:0]    o_max_value,
    output logic                              o_frame_last,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mf3_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [mf3_pkg::DATA_BITS-1:0]     pwdata,
    output logic [mf3_pkg::DATA_BITS-1:0]     prdata,
    output logic                              pready
);
    import mf3_pkg::*;

    // configuration
    logic [SIDE_BITS-1:0]   r_side_length;
    logic [SIDE_BITS-1:0]   r_side_use;
    logic [POS_BITS-1:0]    r_side_m1;
    logic [PTR_BITS-1:0]    r_ptr_last;
    logic [CNT_BITS-1:0]    r_n;
    logic                   cfg_wr;
    logic [SIDE_BITS-1:0]   cfg_side;
    logic [SIDE_BITS-1:0]   cfg_use;
    logic [2*SIDE_BITS-1:0] cfg_sq;

    // counters
    logic [CNT_BITS-1:0]    r_in_cnt;
    logic [CNT_BITS-1:0]    r_out_cnt;
    logic [POS_BITS-1:0]    r_col;
    logic [POS_BITS-1:0]    r_row;
    logic [CNT_BITS-1:0]    n_in_cnt;
    logic [CNT_BITS-1:0]    n_out_cnt;
    logic [POS_BITS-1:0]    n_col;
    logic [POS_BITS-1:0]    n_row;

    // pipeline
    logic                   r_s1_valid;
    t_s1_flags              r_s1_flags;
    t_s1_flags              s1_flags_now;
    logic                   r_out_valid;
    logic [FIELD_BITS-1:0]  r_max_value;
    logic                   r_frame_last;

    logic                   s1_adv;
    logic                   acc;
    logic                   complete;
    logic                   pix_take;
    logic                   emit;
    logic                   push;
    logic                   last_now;

    logic [2*PIXEL_BITS-1:0] ls_rd;
    t_pix                    pix_in;
    t_col                    w_in  [3];
    t_col                    w_col [3];
    t_pix                    w_max [3];
    t_pix                    lft_v;
    t_pix                    rgt_v;
    t_pix                    best;
    t_pix                    result;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SIDE_LENGTH);
    assign prdata = (paddr[2] == REG_SIDE_LENGTH) ?
                    DATA_BITS'(r_side_length) : '0;

    always_comb begin
        cfg_side = pwdata[SIDE_BITS-1:0];
        if (cfg_side == '0) begin
            cfg_use = SIDE_BITS'(1);
        end else if (cfg_side > SIDE_BITS'(MAX_SIDE)) begin
            cfg_use = SIDE_BITS'(MAX_SIDE);
        end else begin
            cfg_use = cfg_side;
        end
        cfg_sq = {{SIDE_BITS{1'b0}}, cfg_use} * {{SIDE_BITS{1'b0}}, cfg_use};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_length <= SIDE_BITS'(SIDE_RESET);
            r_side_use    <= SIDE_BITS'(SIDE_RESET);
            r_side_m1     <= POS_BITS'(SIDE_RESET - 1);
            r_ptr_last    <= PTR_BITS'(SIDE_RESET - 2);
            r_n           <= CNT_BITS'(N_RESET);
        end else if (cfg_wr) begin
            r_side_length <= cfg_side;
            r_side_use    <= cfg_use;
            r_side_m1     <= POS_BITS'(cfg_use - SIDE_BITS'(1));
            r_ptr_last    <= (cfg_use >= SIDE_BITS'(2)) ?
                             PTR_BITS'(cfg_use - SIDE_BITS'(2)) : '0;
            r_n           <= CNT_BITS'(cfg_sq);
        end
    end

    // ---------------- handshake and control ----------------
    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign acc        = i_in_valid && !o_in_stall;
    assign complete   = (r_in_cnt >= r_n);
    assign pix_take   = !i_drain && !complete;
    assign emit       = acc && (complete || (pix_take &&
                        (r_in_cnt >= r_out_cnt + CNT_BITS'(r_side_use) + CNT_BITS'(1))));
    // Past the image every item shifts a filler pixel, except for a one-pixel image.
    assign push       = acc && (pix_take || (complete && (r_side_use != SIDE_BITS'(1))));
    assign last_now   = (r_out_cnt + CNT_BITS'(1) == r_n);

    always_comb begin
        s1_flags_now.rows.up = (r_row != '0);
        s1_flags_now.rows.dn = (r_row != r_side_m1);
        s1_flags_now.lf      = (r_col != '0);
        s1_flags_now.rt      = (r_col != r_side_m1);
        s1_flags_now.single  = (r_side_use == SIDE_BITS'(1));
        s1_flags_now.last    = last_now;
    end

    always_comb begin
        n_in_cnt  = r_in_cnt;
        n_out_cnt = r_out_cnt;
        n_col     = r_col;
        n_row     = r_row;
        if (cfg_wr || (emit && last_now)) begin
            n_in_cnt  = '0;
            n_out_cnt = '0;
            n_col     = '0;
            n_row     = '0;
        end else begin
            if (acc && pix_take) begin
                n_in_cnt = r_in_cnt + CNT_BITS'(1);
            end
            if (emit) begin
                n_out_cnt = r_out_cnt + CNT_BITS'(1);
                if (r_col == r_side_m1) begin
                    n_col = '0;
                    n_row = r_row + 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cnt  <= '0;
            r_out_cnt <= '0;
            r_col     <= '0;
            r_row     <= '0;
        end else begin
            r_in_cnt  <= n_in_cnt;
            r_out_cnt <= n_out_cnt;
            r_col     <= n_col;
            r_row     <= n_row;
        end
    end

    // ---------------- line store and window cells ----------------
    assign pix_in = i_pixel_value[PIXEL_BITS-1:0];

    mf3_line_store u_line_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (cfg_wr),
        .i_push     (push),
        .i_ptr_last (r_ptr_last),
        .i_wr_data  ({ls_rd[PIXEL_BITS-1:0], pix_in}),
        .o_rd_data  (ls_rd)
    );

    // Cell 2 takes the newest column; cell 0 holds the oldest.
    assign w_in[2] = '{top: ls_rd[2*PIXEL_BITS-1:PIXEL_BITS],
                       mid: ls_rd[PIXEL_BITS-1:0],
                       bot: pix_in};
    assign w_in[1] = w_col[2];
    assign w_in[0] = w_col[1];

    for (genvar k = 0; k < 3; k++) begin : g_cell
        mf3_cell u_cell (
            .i_clk     (i_clk),
            .i_shift   (push),
            .i_col     (w_in[k]),
            .i_mask    (r_s1_flags.rows),
            .o_col     (w_col[k]),
            .o_col_max (w_max[k])
        );
    end

    always_comb begin
        lft_v = r_s1_flags.lf ? w_max[0] : '0;
        rgt_v = r_s1_flags.rt ? w_max[2] : '0;
        best  = w_max[1];
        if (lft_v > best) begin
            best = lft_v;
        end
        if (rgt_v > best) begin
            best = rgt_v;
        end
        // A one-pixel image: the pixel itself still sits in the newest cell.
        result = r_s1_flags.single ? w_col[2].bot : best;
    end

    // ---------------- pipeline registers ----------------
    // The window stage loads whenever the input is open, even while the
    // output register holds a stalled item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (!o_in_stall) begin
                r_s1_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_s1_flags <= s1_flags_now;
        end
        if (s1_adv && r_s1_valid) begin
            r_max_value  <= FIELD_BITS'(result);
            r_frame_last <= r_s1_flags.last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_max_value  = r_max_value;
    assign o_frame_last = r_frame_last;

    `MF3_ASSERT(a_cnt_order, i_clk, i_rst_n, r_out_cnt <= r_in_cnt, "results ran ahead of pixels")
    `MF3_ASSERT(a_last_clears, i_clk, i_rst_n, emit && last_now |=> r_in_cnt == '0 && r_out_cnt == '0, "counts not cleared after final result")
    `MF3_ASSERT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_flags), "blocked window stage lost its item")
    `MF3_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !r_out_valid && !r_s1_valid, "pipeline not empty after reset")

endmodule

>>> rtl/mf3_cell.sv
// Window cell: one column of three pixels and its masked column maximum.
`timescale 1ns / 1ps
module mf3_cell (
    input  logic                i_clk,
    input  logic                i_shift,
    input  mf3_pkg::t_col       i_col,
    input  mf3_pkg::t_row_mask  i_mask,
    output mf3_pkg::t_col       o_col,
    output mf3_pkg::t_pix       o_col_max
);
    import mf3_pkg::*;

    t_col r_col;
    t_pix top_v;
    t_pix bot_v;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    // Rows outside the image count as zero.
    always_comb begin
        top_v = i_mask.up ? r_col.top : '0;
        bot_v = i_mask.dn ? r_col.bot : '0;
        o_col_max = r_col.mid;
        if (top_v > o_col_max) begin
            o_col_max = top_v;
        end
        if (bot_v > o_col_max) begin
            o_col_max = bot_v;
        end
    end

    assign o_col = r_col;

endmodule

>>> rtl/mf3_line_store.sv
// Line store: two row delays sharing one circular memory and pointer.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mf3_line_store (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_clear,
    input  logic                              i_push,
    input  logic [mf3_pkg::PTR_BITS-1:0]      i_ptr_last,
    input  logic [2*mf3_pkg::PIXEL_BITS-1:0]  i_wr_data,
    output logic [2*mf3_pkg::PIXEL_BITS-1:0]  o_rd_data
);
    import mf3_pkg::*;

    logic [2*PIXEL_BITS-1:0] r_mem [MAX_SIDE];
    logic [2*PIXEL_BITS-1:0] r_rd;
    logic [PTR_BITS-1:0]     r_ptr;
    logic [PTR_BITS-1:0]     n_ptr;

    always_comb begin
        n_ptr = r_ptr;
        if (i_clear) begin
            n_ptr = '0;
        end else if (i_push) begin
            n_ptr = (r_ptr == i_ptr_last) ? '0 : r_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else begin
            r_ptr <= n_ptr;
        end
    end

    // Read before write: the old entry leaves as the new one lands.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_rd         <= r_mem[r_ptr];
            r_mem[r_ptr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd;

    `MF3_ASSERT(a_ptr_in_period, i_clk, i_rst_n, r_ptr <= i_ptr_last, "line store pointer past period")

endmodule

>>> verif/tb_neighbourhood_max_filter_3x3_top.sv
// Self-checking testbench of the 3x3 neighbourhood max filter.
`timescale 1ns / 1ps
module tb_neighbourhood_max_filter_3x3_top;
    import mf3_pkg::*;

    localparam int REG_UNUSED    = 1;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 260;
    localparam int WIDE_ITEMS    = 12;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int IDLE_PCT      = 15;

    typedef struct packed {
        logic [FIELD_BITS-1:0] max_value;
        logic                  frame_last;
    } t_filter_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [FIELD_BITS-1:0] i_pixel_value = '0;
    logic                  i_drain = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [FIELD_BITS-1:0] o_max_value;
    logic                  o_frame_last;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_BITS-1:0]  paddr = '0;
    logic [DATA_BITS-1:0]  pwdata = '0;
    logic [DATA_BITS-1:0]  prdata;
    logic                  pready;

    // Predictor state: side register, image counters and the pixels of the current image
    logic [SIDE_BITS-1:0]  side_reg = SIDE_BITS'(SIDE_RESET);
    int unsigned           pix_in_count = 0;
    int unsigned           result_count = 0;
    t_pix                  frame_pix [int unsigned];
    t_filter_result        pending_max_q [$];
    t_filter_result        head;

    int unsigned           fail_count = 0;
    int unsigned           useful_items = 0;
    int unsigned           cycle_count = 0;
    int unsigned           hold_requests = 0;
    int unsigned           hold_served = 0;
    int unsigned           hold_left = 0;
    bit                    no_idle = 1'b0;

    neighbourhood_max_filter_3x3_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel_value (i_pixel_value),
        .i_drain       (i_drain),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_max_value   (o_max_value),
        .o_frame_last  (o_frame_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int unsigned side_in_force();
        int unsigned s;
        s = side_reg;
        if (s < 1) s = 1;
        if (s > MAX_SIDE) s = MAX_SIDE;
        return s;
    endfunction

    function automatic t_pix window_max(int unsigned p, int unsigned s);
        int   r;
        int   c;
        int   rr;
        int   cc;
        t_pix best;
        r = int'(p / s);
        c = int'(p % s);
        best = '0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                rr = r + dr;
                cc = c + dc;
                if (rr >= 0 && cc >= 0 && rr < int'(s) && cc < int'(s)) begin
                    if (frame_pix[rr * s + cc] > best) best = frame_pix[rr * s + cc];
                end
            end
        end
        return best;
    endfunction

    // Returns 1 unless the block drops the item outright
    function automatic bit predict_item(t_pix pix, logic drain);
        int unsigned    s;
        int unsigned    n;
        bit             emit;
        bit             took;
        t_filter_result res;
        s = side_in_force();
        n = s * s;
        emit = 1'b0;
        took = 1'b0;
        if (!drain && pix_in_count < n) begin
            frame_pix[pix_in_count] = pix;
            pix_in_count++;
            took = 1'b1;
            if (pix_in_count >= result_count + s + 2) emit = 1'b1;
        end else if (pix_in_count >= n && result_count < n) begin
            emit = 1'b1;
        end
        if (emit) begin
            took = 1'b1;
            res.max_value = window_max(result_count, s);
            res.frame_last = (result_count + 1 == n);
            pending_max_q.push_back(res);
            if (res.frame_last) begin
                pix_in_count = 0;
                result_count = 0;
                frame_pix.delete();
            end else begin
                result_count++;
            end
        end
        return took;
    endfunction

    function automatic t_pix pick_pixel();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return t_pix'(1) << $urandom_range(PIXEL_BITS - 1);
            3: return t_pix'($urandom_range(15));
            default: return t_pix'($urandom);
        endcase
    endfunction

    function automatic int unsigned pick_side();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 75) return $urandom_range(0, 6);
        if (r < 95) return $urandom_range(7, 12);
        return $urandom_range(13, 16);
    endfunction

    task automatic send_item(input t_pix pix, input logic drain);
        // idle at random before the item, so that about IDLE_PCT percent of cycles are empty
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_value <= pix;
        i_drain <= drain;
        do @(posedge i_clk); while (o_in_stall);
        if (predict_item(pix, drain)) useful_items++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_max_q.size() != 0) @(posedge i_clk);
        // the item just taken may still be in flight without a result
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input int idx, input logic [DATA_BITS-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_BITS'(idx * 4);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        if (idx == int'(REG_SIDE_LENGTH)) begin
            side_reg = value[SIDE_BITS-1:0];
            pix_in_count = 0;
            result_count = 0;
            frame_pix.delete();
        end
    endtask

    task automatic check_side_readback(input logic [SIDE_BITS-1:0] want);
        logic [DATA_BITS-1:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_BITS'(int'(REG_SIDE_LENGTH) * 4);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (got[SIDE_BITS-1:0] !== want) begin
            $error("side_length: expected %0d, got %0d", want, got[SIDE_BITS-1:0]);
            fail_count++;
        end
    endtask

    task automatic set_side(input int unsigned value);
        wait_idle();
        apb_write(int'(REG_SIDE_LENGTH), DATA_BITS'(value));
        check_side_readback(SIDE_BITS'(value));
    endtask

    // One whole image, optionally with stray drains, then side+1 flushing items
    task automatic send_frame(input bit noisy);
        int unsigned s;
        s = side_in_force();
        for (int unsigned k = 0; k < s * s; k++) begin
            if (noisy && $urandom_range(99) < 10) send_item(pick_pixel(), 1'b1);
            send_item(pick_pixel(), 1'b0);
        end
        for (int unsigned k = 0; k <= s; k++) send_item(pick_pixel(), logic'($urandom_range(1)));
    endtask

    task automatic test_default_side();
        check_side_readback(SIDE_BITS'(SIDE_RESET));
        repeat (70) send_item(pick_pixel(), 1'b0);
        wait_idle();
    endtask

    task automatic test_single_pixel_image();
        set_side(0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h1234, 1'b1);
        // drain with no image under way: drop
        send_item(16'h0000, 1'b1);
        send_item(16'h0000, 1'b0);
        // pixel after a complete image acts as a drain
        send_item(16'h5A5A, 1'b0);
        wait_idle();
    endtask

    task automatic test_two_by_two();
        set_side(2);
        send_item(16'hAAAA, 1'b1);
        send_item(16'h8000, 1'b0);
        send_item(16'h0001, 1'b0);
        send_item(16'h5555, 1'b1);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h7FFF, 1'b0);
        send_item(16'h0000, 1'b1);
        send_item(16'h00FF, 1'b0);
        send_item(16'hFF00, 1'b1);
        wait_idle();
    endtask

    task automatic test_unused_register();
        set_side(3);
        repeat (5) send_item(pick_pixel(), 1'b0);
        wait_idle();
        // write outside the register map: image must carry on untouched
        apb_write(REG_UNUSED, DATA_BITS'(5));
        repeat (4) send_item(pick_pixel(), 1'b0);
        repeat (4) send_item(pick_pixel(), 1'b1);
        wait_idle();
    endtask

    task automatic test_abandoned_image();
        set_side(3);
        repeat (6) send_item(pick_pixel(), 1'b0);
        set_side(3);
        send_frame(1'b0);
        wait_idle();
    endtask

    // Widest and over-range sides: too few pixels for a result, so nothing may leave
    task automatic test_widest_side();
        set_side(MAX_SIDE);
        repeat (WIDE_ITEMS) send_item(pick_pixel(), 1'b0);
        set_side((1 << SIDE_BITS) - 1);
        repeat (WIDE_ITEMS) send_item(pick_pixel(), 1'b0);
        wait_idle();
    endtask

    task automatic test_output_hold_off();
        set_side(6);
        hold_requests++;
        send_frame(1'b1);
        wait_idle();
    endtask

    task automatic test_random_images();
        int unsigned start_items;
        int unsigned frame_no;
        int unsigned s;
        int unsigned cut;
        start_items = useful_items;
        frame_no = 0;
        while (useful_items - start_items < RANDOM_ITEMS) begin
            no_idle = (frame_no >= 3 && frame_no < 6);
            if (frame_no == 0 || $urandom_range(1) == 1) set_side(pick_side());
            s = side_in_force();
            if ($urandom_range(9) == 0) begin
                cut = $urandom_range(1, s * s + s);
                repeat (cut) send_item(pick_pixel(), logic'($urandom_range(99) < 10));
                set_side(pick_side());
            end else begin
                send_frame(1'b1);
            end
            frame_no++;
        end
        no_idle = 1'b0;
        wait_idle();
    endtask

    // Check each result; drive the output stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_max_q.size() == 0) begin
                $error("unexpected result: max_value %0d, frame_last %0d",
                       o_max_value, o_frame_last);
                fail_count++;
            end else begin
                head = pending_max_q.pop_front();
                if (o_max_value !== head.max_value) begin
                    $error("max_value: expected %0d, got %0d", head.max_value, o_max_value);
                    fail_count++;
                end
                if (o_frame_last !== head.frame_last) begin
                    $error("frame_last: expected %0d, got %0d", head.frame_last, o_frame_last);
                    fail_count++;
                end
            end
        end
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("neighbourhood_max_filter_3x3_top test failed");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_side();
        test_single_pixel_image();
        test_two_by_two();
        test_unused_register();
        test_abandoned_image();
        test_widest_side();
        test_output_hold_off();
        test_random_images();
        wait_idle();
        if (pending_max_q.size() != 0) begin
            $error("%0d expected results never arrived", pending_max_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("neighbourhood_max_filter_3x3_top test passed");
        end else begin
            $display("neighbourhood_max_filter_3x3_top test failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/mf3_pkg.sv
rtl/mf3_cell.sv
rtl/mf3_line_store.sv
rtl/neighbourhood_max_filter_3x3_top.sv
verif/tb_neighbourhood_max_filter_3x3_top.sv
